>>> hw/rtl/cmbi_pkg.sv
// Shared types, codes and constants for the cartridge mapper block.
// Used by cmbi_regs, cmbi_irq, cmbi_xlate and cartridge_mapper_bank_irq.
`default_nettype none

package cmbi_pkg;

   // Request kinds carried on req_tuser
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_WRITE  = 3'd1;
   localparam logic [2:0] REQ_PRG    = 3'd2;
   localparam logic [2:0] REQ_CHR_RD = 3'd3;
   localparam logic [2:0] REQ_CHR_WR = 3'd4;
   localparam logic [2:0] REQ_NT     = 3'd5;
   localparam logic [2:0] REQ_WRAM   = 3'd6;

   // Memory select codes carried on rsp_tuser
   localparam logic [2:0] SEL_PRG_ROM = 3'd0;
   localparam logic [2:0] SEL_CHR_ROM = 3'd1;
   localparam logic [2:0] SEL_CHR_RAM = 3'd2;
   localparam logic [2:0] SEL_NT_RAM  = 3'd3;
   localparam logic [2:0] SEL_WRAM    = 3'd4;
   localparam logic [2:0] SEL_NONE    = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CFG_PRG_LOG2 = 2'd0;
   localparam logic [1:0] CFG_CHR_LOG2 = 2'd1;
   localparam logic [1:0] CFG_SWAP     = 2'd2;

   localparam logic [4:0] PRG_LOG2_RESET = 5'd19;
   localparam logic [4:0] PRG_LOG2_MIN   = 5'd13;
   localparam logic [4:0] PRG_LOG2_MAX   = 5'd19;

   // Scanline prescaler: 341 PPU dots per line, 3 dots per CPU cycle
   localparam logic [9:0] PRESCALE_LOAD = 10'd341;
   localparam logic [9:0] PRESCALE_STEP = 10'd3;

   // Decoded mapper register write
   typedef enum logic [2:0] {
      WR_NONE,
      WR_PRG,
      WR_CHR,
      WR_MIRROR,
      WR_LATCH,
      WR_IRQ_CTRL,
      WR_IRQ_ACK
   } wr_kind_type;

   typedef struct packed {
      wr_kind_type kind;
      logic [1:0]  prg_idx;
      logic [2:0]  chr_idx;
      logic [7:0]  data;
   } reg_wr_type;

   // Static configuration
   typedef struct packed {
      logic [4:0] prg_log2;
      logic [4:0] chr_log2;
      logic       swap;
   } cfg_type;

   // Banking state seen by the address translation
   typedef struct packed {
      logic [2:0][5:0] prg;
      logic [7:0][7:0] chr;
      logic [1:0]      mirror;
      logic            wram_en;
   } bank_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/cmbi_regs.sv
// Bank, mirroring and work RAM enable registers plus the static configuration.
// Depends on cmbi_pkg.
`default_nettype none

module cmbi_regs (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [1:0]               csr_index,
   input  wire logic [4:0]               csr_wdata,
   input  wire cmbi_pkg::reg_wr_type     wr,
   output cmbi_pkg::cfg_type             cfg,
   output cmbi_pkg::bank_state_type      banks
);

   logic [2:0][5:0] prg_ff, prg_in;
   logic [7:0][7:0] chr_ff, chr_in;
   logic [1:0]      mirror_ff, mirror_in;
   logic            wram_en_ff, wram_en_in;
   logic [4:0]      prg_log2_ff, chr_log2_ff;
   logic            swap_ff;

   // Next banking state from a decoded register write
   always_comb begin
      prg_in     = prg_ff;
      chr_in     = chr_ff;
      mirror_in  = mirror_ff;
      wram_en_in = wram_en_ff;
      unique case (wr.kind)
         cmbi_pkg::WR_PRG: begin
            prg_in[wr.prg_idx] = wr.data[5:0];
         end
         cmbi_pkg::WR_CHR: begin
            chr_in[wr.chr_idx] = wr.data;
         end
         cmbi_pkg::WR_MIRROR: begin
            mirror_in  = wr.data[1:0];
            wram_en_in = wr.data[7];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff     <= '0;
         chr_ff     <= '0;
         mirror_ff  <= '0;
         wram_en_ff <= 1'b0;
      end else begin
         prg_ff     <= prg_in;
         chr_ff     <= chr_in;
         mirror_ff  <= mirror_in;
         wram_en_ff <= wram_en_in;
      end
   end

   // Configuration writes; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_log2_ff <= cmbi_pkg::PRG_LOG2_RESET;
         chr_log2_ff <= 5'd0;
         swap_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            cmbi_pkg::CFG_PRG_LOG2: prg_log2_ff <= csr_wdata;
            cmbi_pkg::CFG_CHR_LOG2: chr_log2_ff <= csr_wdata;
            cmbi_pkg::CFG_SWAP:     swap_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.prg_log2  = prg_log2_ff;
   assign cfg.chr_log2  = chr_log2_ff;
   assign cfg.swap      = swap_ff;
   assign banks.prg     = prg_ff;
   assign banks.chr     = chr_ff;
   assign banks.mirror  = mirror_ff;
   assign banks.wram_en = wram_en_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cmbi_irq.sv
// IRQ counter with scanline prescaler, latch, repeat and acknowledge.
// Depends on cmbi_pkg.
`default_nettype none

module cmbi_irq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire cmbi_pkg::reg_wr_type wr,
   output logic                      pend_next,
   output logic                      pend_now
);

   logic [7:0] count_ff, count_in;
   logic [7:0] latch_ff, latch_in;
   logic       en_ff, en_in;
   logic       rep_ff, rep_in;
   logic       scan_ff, scan_in;
   logic       pend_ff, pend_in;
   logic [9:0] pre_ff, pre_in;
   logic       fire;

   always_comb begin
      count_in = count_ff;
      latch_in = latch_ff;
      en_in    = en_ff;
      rep_in   = rep_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      pre_in   = pre_ff;
      fire     = 1'b0;

      // Counter clocking on a CPU cycle beat
      if (tick && en_ff) begin
         if (scan_ff) begin
            if (pre_ff <= cmbi_pkg::PRESCALE_STEP) begin
               pre_in = pre_ff + (cmbi_pkg::PRESCALE_LOAD - cmbi_pkg::PRESCALE_STEP);
               fire   = 1'b1;
            end else begin
               pre_in = pre_ff - cmbi_pkg::PRESCALE_STEP;
            end
         end else begin
            fire = 1'b1;
         end
         if (fire) begin
            if (count_ff == 8'hff) begin
               count_in = latch_ff;
               pend_in  = 1'b1;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
      end

      // Register writes
      unique case (wr.kind)
         cmbi_pkg::WR_LATCH: begin
            latch_in = wr.data;
         end
         cmbi_pkg::WR_IRQ_CTRL: begin
            rep_in  = wr.data[0];
            en_in   = wr.data[1];
            scan_in = ~wr.data[2];
            pend_in = 1'b0;
            if (wr.data[1]) begin
               count_in = latch_ff;
               pre_in   = cmbi_pkg::PRESCALE_LOAD;
            end
         end
         cmbi_pkg::WR_IRQ_ACK: begin
            pend_in = 1'b0;
            en_in   = rep_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         latch_ff <= '0;
         en_ff    <= 1'b0;
         rep_ff   <= 1'b0;
         scan_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         pre_ff   <= cmbi_pkg::PRESCALE_LOAD;
      end else begin
         count_ff <= count_in;
         latch_ff <= latch_in;
         en_ff    <= en_in;
         rep_ff   <= rep_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         pre_ff   <= pre_in;
      end
   end

   assign pend_next = pend_in;
   assign pend_now  = pend_ff;

   // Pending only sets from a counter overflow on a tick
   a_pend_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> $past(tick))
      else $error("IRQ pending set without a tick");

   // Enabling write reloads the counter from the latch
   a_ctrl_reload: assert property (@(posedge clock) disable iff (reset)
      (wr.kind == cmbi_pkg::WR_IRQ_CTRL && wr.data[1]) |=>
         (count_ff == $past(latch_ff) && pre_ff == cmbi_pkg::PRESCALE_LOAD))
      else $error("IRQ control write did not reload counter");

endmodule

`default_nettype wire

>>> hw/rtl/cmbi_xlate.sv
// Address translation: PRG, CHR, nametable and work RAM mapping.
// Depends on cmbi_pkg; purely combinational.
`default_nettype none

module cmbi_xlate (
   input  wire logic [2:0]                req_type,
   input  wire logic [15:0]               bus_address,
   input  wire cmbi_pkg::cfg_type         cfg,
   input  wire cmbi_pkg::bank_state_type  banks,
   output logic [18:0]                    mem_address,
   output logic [2:0]                     mem_select,
   output logic                           access_allowed
);

   logic [4:0]  prg_lg;
   logic [18:0] prg_mask;
   logic [5:0]  prg_win;
   logic [18:0] prg_phys;
   logic [7:0]  chr_page;
   logic [17:0] chr_lin;
   logic [17:0] chr_mask;
   logic [10:0] nt_addr;

   // PRG: clamp ROM size, last 8 KiB window fixed to the last bank
   always_comb begin
      if (cfg.prg_log2 < cmbi_pkg::PRG_LOG2_MIN) begin
         prg_lg = cmbi_pkg::PRG_LOG2_MIN;
      end else if (cfg.prg_log2 > cmbi_pkg::PRG_LOG2_MAX) begin
         prg_lg = cmbi_pkg::PRG_LOG2_MAX;
      end else begin
         prg_lg = cfg.prg_log2;
      end
      prg_mask = ~(19'h7ffff << prg_lg);
      unique case (bus_address[15:13])
         3'b100:  prg_win = banks.prg[0];
         3'b101:  prg_win = banks.prg[1];
         3'b110:  prg_win = banks.prg[2];
         3'b111:  prg_win = prg_mask[18:13];
         default: prg_win = 6'd0;
      endcase
      prg_phys = {prg_win, bus_address[12:0]} & prg_mask;
   end

   // CHR: 1 KiB banks chosen by A12..A10; shifts past 18 leave the mask all ones
   assign chr_page = banks.chr[bus_address[12:10]];
   assign chr_lin  = {chr_page, bus_address[9:0]};
   assign chr_mask = ~(18'h3ffff << cfg.chr_log2);

   // Nametable mirroring
   always_comb begin
      unique case (banks.mirror)
         2'd0:    nt_addr = bus_address[10:0];
         2'd1:    nt_addr = {bus_address[11], bus_address[9:0]};
         2'd2:    nt_addr = {1'b0, bus_address[9:0]};
         default: nt_addr = {1'b1, bus_address[9:0]};
      endcase
   end

   // Result by request kind
   always_comb begin
      mem_address    = 19'd0;
      mem_select     = cmbi_pkg::SEL_NONE;
      access_allowed = 1'b0;
      unique case (req_type)
         cmbi_pkg::REQ_PRG: begin
            mem_address    = prg_phys;
            mem_select     = cmbi_pkg::SEL_PRG_ROM;
            access_allowed = 1'b1;
         end
         cmbi_pkg::REQ_CHR_RD: begin
            if (cfg.chr_log2 != 5'd0) begin
               mem_address = {1'b0, chr_lin & chr_mask};
               mem_select  = cmbi_pkg::SEL_CHR_ROM;
            end else begin
               mem_address = {6'd0, chr_lin[12:0]};
               mem_select  = cmbi_pkg::SEL_CHR_RAM;
            end
            access_allowed = 1'b1;
         end
         cmbi_pkg::REQ_CHR_WR: begin
            mem_address    = {6'd0, chr_lin[12:0]};
            mem_select     = cmbi_pkg::SEL_CHR_RAM;
            access_allowed = 1'b1;
         end
         cmbi_pkg::REQ_NT: begin
            mem_address    = {8'd0, nt_addr};
            mem_select     = cmbi_pkg::SEL_NT_RAM;
            access_allowed = 1'b1;
         end
         cmbi_pkg::REQ_WRAM: begin
            mem_address    = {6'd0, bus_address[12:0]};
            mem_select     = cmbi_pkg::SEL_WRAM;
            access_allowed = banks.wram_en;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/cartridge_mapper_bank_irq.sv
// Cartridge mapper with PRG/CHR banking, mirroring and IRQ counter: top level.
// Instantiates cmbi_regs, cmbi_irq and cmbi_xlate; depends on cmbi_pkg.
//
// One bus event per beat on req_*: a CPU cycle tick, a mapper register write or an
// address to translate. Every event yields exactly one response beat on rsp_*
// carrying the physical address, memory select, access-allowed bit and the IRQ line
// as it stands after the event. Throughput is one event per clock while rsp_tready
// keeps the response register moving; each event passes through the input register
// and then the response register, with the translation and counter update between
// them. Bank and IRQ state update as an event leaves the input register, so events
// take effect strictly in order. The csr_* port writes the ROM size and address-swap
// settings and is meant to be used while no events are in flight.
`default_nettype none

module cartridge_mapper_bank_irq (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [15:0] bus_address, [23:16] write_data
   input  wire logic [2:0]  req_tuser,   // [2:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [18:0] mem_address, [19] access_allowed,
                                         // [20] irq_line, [23:21] zero
   output logic [2:0]       rsp_tuser,   // [2:0] mem_select
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   // Register write address keys {A15..A12, A3}
   localparam logic [4:0] RA_PRG0  = 5'h10;
   localparam logic [4:0] RA_PRG1  = 5'h11;
   localparam logic [4:0] RA_PRG2  = 5'h12;
   localparam logic [4:0] RA_CHR0  = 5'h14;
   localparam logic [4:0] RA_CHR1  = 5'h15;
   localparam logic [4:0] RA_CHR2  = 5'h16;
   localparam logic [4:0] RA_CHR3  = 5'h17;
   localparam logic [4:0] RA_CHR4  = 5'h18;
   localparam logic [4:0] RA_CHR5  = 5'h19;
   localparam logic [4:0] RA_CHR6  = 5'h1a;
   localparam logic [4:0] RA_CHR7  = 5'h1b;
   localparam logic [4:0] RA_MIRR  = 5'h1c;
   localparam logic [4:0] RA_LATCH = 5'h1d;
   localparam logic [4:0] RA_CTRL  = 5'h1e;
   localparam logic [4:0] RA_ACK   = 5'h1f;

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_type_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_data_ff;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [18:0] rsp_addr_ff;
   logic [2:0]  rsp_sel_ff;
   logic        rsp_allow_ff;
   logic        rsp_irq_ff;

   logic        advance;
   logic        take;
   logic        proc;
   logic        tick;
   logic [15:0] wa;
   logic [4:0]  key;

   cmbi_pkg::reg_wr_type     wr;
   cmbi_pkg::cfg_type        cfg;
   cmbi_pkg::bank_state_type banks;

   logic [18:0] x_addr;
   logic [2:0]  x_sel;
   logic        x_allow;
   logic        pend_next;
   logic        pend_now;

   // Handshake: the input register refills whenever its beat moves on
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = advance || !s1_valid_ff;
   assign take        = req_tvalid && req_tready;
   assign proc        = s1_valid_ff && advance;
   assign s1_valid_in = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = proc || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_type_ff <= req_tuser;
         s1_addr_ff <= req_tdata[15:0];
         s1_data_ff <= req_tdata[23:16];
      end
   end

   // Register write decode, with optional A4 -> A3 swap
   assign wa  = cfg.swap ? {s1_addr_ff[15:12], 8'd0, s1_addr_ff[4], 3'd0} : s1_addr_ff;
   assign key = {wa[15:12], wa[3]};
   assign tick = proc && (s1_type_ff == cmbi_pkg::REQ_TICK);

   always_comb begin
      wr.kind    = cmbi_pkg::WR_NONE;
      wr.prg_idx = {wa[12], wa[3]};
      wr.chr_idx = {~wa[13], wa[12], wa[3]};
      wr.data    = s1_data_ff;
      if (proc && s1_type_ff == cmbi_pkg::REQ_WRITE) begin
         unique case (key)
            RA_PRG0, RA_PRG1, RA_PRG2: wr.kind = cmbi_pkg::WR_PRG;
            RA_CHR0, RA_CHR1, RA_CHR2, RA_CHR3,
            RA_CHR4, RA_CHR5, RA_CHR6, RA_CHR7: wr.kind = cmbi_pkg::WR_CHR;
            RA_MIRR:  wr.kind = cmbi_pkg::WR_MIRROR;
            RA_LATCH: wr.kind = cmbi_pkg::WR_LATCH;
            RA_CTRL:  wr.kind = cmbi_pkg::WR_IRQ_CTRL;
            RA_ACK:   wr.kind = cmbi_pkg::WR_IRQ_ACK;
            default:  wr.kind = cmbi_pkg::WR_NONE;
         endcase
      end
   end

   cmbi_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr        (wr),
      .cfg       (cfg),
      .banks     (banks)
   );

   cmbi_irq u_irq (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .wr        (wr),
      .pend_next (pend_next),
      .pend_now  (pend_now)
   );

   cmbi_xlate u_xlate (
      .req_type       (s1_type_ff),
      .bus_address    (s1_addr_ff),
      .cfg            (cfg),
      .banks          (banks),
      .mem_address    (x_addr),
      .mem_select     (x_sel),
      .access_allowed (x_allow)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_addr_ff  <= x_addr;
         rsp_sel_ff   <= x_sel;
         rsp_allow_ff <= x_allow;
         rsp_irq_ff   <= pend_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_irq_ff, rsp_allow_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_sel_ff;

   // A new response only comes from a beat held in the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response appeared without an input beat");

   // A stalled input beat is neither lost nor overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=>
         (s1_valid_ff && $stable(s1_type_ff) && $stable(s1_addr_ff) && $stable(s1_data_ff)))
      else $error("stalled input beat changed");

   // Reported IRQ line matches the counter state after the event
   a_irq_match: assert property (@(posedge clock) disable iff (reset)
      proc |=> (rsp_irq_ff == pend_now))
      else $error("response IRQ line disagrees with pending flag");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for cartridge_mapper_bank_irq: drives bus events over the req_ stream and checks
// every rsp_ beat against a tracker of banks, mirroring and IRQ counter. Needs cmbi_pkg.

module tb;
   import cmbi_pkg::*;

   // Request kind the block leaves unused
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // Mapper register addresses as decoded (upper nibble and A3)
   localparam logic [15:0] REG_PRG0     = 16'h8000;
   localparam logic [15:0] REG_PRG1     = 16'h8008;
   localparam logic [15:0] REG_PRG2     = 16'h9000;
   localparam logic [15:0] REG_SOUND    = 16'h9008;
   localparam logic [15:0] REG_CHR0     = 16'ha000;
   localparam logic [15:0] REG_CHR7     = 16'hd008;
   localparam logic [15:0] REG_MIRROR   = 16'he000;
   localparam logic [15:0] REG_LATCH    = 16'he008;
   localparam logic [15:0] REG_IRQ_CTRL = 16'hf000;
   localparam logic [15:0] REG_IRQ_ACK  = 16'hf008;

   // Nametable mirroring modes
   localparam logic [1:0] MIRROR_VERT   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZ  = 2'd1;
   localparam logic [1:0] MIRROR_SCR_LO = 2'd2;
   localparam logic [1:0] MIRROR_SCR_HI = 2'd3;

   localparam int unsigned CHR_LOG2_MAX = 18;

   localparam int ITEMS_PER_PHASE = 350;
   localparam int HOLD_AT         = 700;
   localparam int HOLD_LEN        = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      logic [18:0] mem_address;
      logic [2:0]  mem_select;
      logic        access_allowed;
      logic        irq_line;
   } mapper_rsp_type;

   // Tracks bank/IRQ state and holds the responses still owed by the block
   class bank_irq_tracker_type;
      logic [4:0]  prg_log2;
      logic [4:0]  chr_log2;
      logic        swap;
      logic [5:0]  prg_bk [3];
      logic [7:0]  chr_bk [8];
      logic [1:0]  mirror;
      logic        wram_en;
      logic [7:0]  irq_count;
      logic [7:0]  irq_latch;
      logic        irq_en;
      logic        irq_rep;
      logic        irq_scan;
      logic        irq_pending;
      int unsigned prescale;
      mapper_rsp_type expected_rsp [$];
      int          checked;
      int          mismatches;

      function new();
         prg_log2 = PRG_LOG2_RESET;
         chr_log2 = '0;
         swap = 1'b0;
         foreach (prg_bk[i]) prg_bk[i] = '0;
         foreach (chr_bk[i]) chr_bk[i] = '0;
         mirror = MIRROR_VERT;
         wram_en = 1'b0;
         irq_count = '0;
         irq_latch = '0;
         irq_en = 1'b0;
         irq_rep = 1'b0;
         irq_scan = 1'b0;
         irq_pending = 1'b0;
         prescale = 32'(PRESCALE_LOAD);
         checked = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [4:0] value);
         case (index)
            CFG_PRG_LOG2: prg_log2 = value;
            CFG_CHR_LOG2: chr_log2 = value;
            CFG_SWAP:     swap = value[0];
            default: ;
         endcase
      endfunction

      // Apply one accepted event and queue the response it produces
      function void note_event(logic [2:0] kind, logic [15:0] bus_addr, logic [7:0] wdata);
         int unsigned a, m, pidx, cidx, lg, span, offset, linear;
         logic        fire;
         mapper_rsp_type r;
         r.mem_address = '0;
         r.mem_select = SEL_NONE;
         r.access_allowed = 1'b0;
         a = 32'(bus_addr);
         linear = (a & 32'h3ff) | (32'(chr_bk[(a >> 10) & 7]) << 10);
         case (kind)
            REQ_TICK: begin
               if (irq_en) begin
                  fire = 1'b1;
                  if (irq_scan) begin
                     if (prescale <= PRESCALE_STEP) begin
                        prescale = prescale + PRESCALE_LOAD - PRESCALE_STEP;
                     end else begin
                        prescale = prescale - PRESCALE_STEP;
                        fire = 1'b0;
                     end
                  end
                  if (fire) begin
                     if (irq_count == 8'hff) begin
                        irq_count = irq_latch;
                        irq_pending = 1'b1;
                     end else begin
                        irq_count = irq_count + 8'd1;
                     end
                  end
               end
            end
            REQ_WRITE: begin
               // submapper 2: A4 takes the place of A3
               if (swap) a = (a & 32'hf000) | ((a >> 1) & 32'h8);
               pidx = ((a >> 11) & 2) | ((a >> 3) & 1);
               cidx = (((a + 32'h2000) >> 11) & 6) | ((a >> 3) & 1);
               m = a & 32'hf008;
               if (m == REG_PRG0 || m == REG_PRG1 || m == REG_PRG2) begin
                  prg_bk[pidx & 3] = wdata[5:0];
               end else if (m >= REG_CHR0 && m <= REG_CHR7) begin
                  chr_bk[cidx & 7] = wdata;
               end else if (m == REG_MIRROR) begin
                  mirror = wdata[1:0];
                  wram_en = wdata[7];
               end else if (m == REG_LATCH) begin
                  irq_latch = wdata;
               end else if (m == REG_IRQ_CTRL) begin
                  // bit0 repeat, bit1 enable, bit2 cycle mode
                  irq_rep = wdata[0];
                  irq_en = wdata[1];
                  irq_scan = !wdata[2];
                  irq_pending = 1'b0;
                  if (irq_en) begin
                     irq_count = irq_latch;
                     prescale = 32'(PRESCALE_LOAD);
                  end
               end else if (m == REG_IRQ_ACK) begin
                  irq_pending = 1'b0;
                  irq_en = irq_rep;
               end
            end
            REQ_PRG: begin
               lg = 32'(prg_log2);
               if (lg < PRG_LOG2_MIN) lg = 32'(PRG_LOG2_MIN);
               if (lg > PRG_LOG2_MAX) lg = 32'(PRG_LOG2_MAX);
               span = 32'd1 << lg;
               case (a & 32'he000)
                  32'h8000: offset = 32'(prg_bk[0]) << 13;
                  32'ha000: offset = 32'(prg_bk[1]) << 13;
                  32'hc000: offset = 32'(prg_bk[2]) << 13;
                  32'he000: offset = span - 32'h2000;  // fixed last bank
                  default:  offset = 0;
               endcase
               r.mem_address = 19'(((a & 32'h1fff) | offset) & (span - 1));
               r.mem_select = SEL_PRG_ROM;
               r.access_allowed = 1'b1;
            end
            REQ_CHR_RD: begin
               if (chr_log2 != 0) begin
                  lg = (chr_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : 32'(chr_log2);
                  r.mem_address = 19'(linear & ((32'd1 << lg) - 1));
                  r.mem_select = SEL_CHR_ROM;
               end else begin
                  r.mem_address = 19'(linear & 32'h1fff);
                  r.mem_select = SEL_CHR_RAM;
               end
               r.access_allowed = 1'b1;
            end
            REQ_CHR_WR: begin
               r.mem_address = 19'(linear & 32'h1fff);
               r.mem_select = SEL_CHR_RAM;
               r.access_allowed = 1'b1;
            end
            REQ_NT: begin
               case (mirror)
                  MIRROR_VERT:   r.mem_address = 19'(a & 32'h7ff);
                  MIRROR_HORIZ:  r.mem_address = 19'(((a >> 1) & 32'h400) | (a & 32'h3ff));
                  MIRROR_SCR_LO: r.mem_address = 19'(a & 32'h3ff);
                  default:       r.mem_address = 19'(32'h400 | (a & 32'h3ff));
               endcase
               r.mem_select = SEL_NT_RAM;
               r.access_allowed = 1'b1;
            end
            REQ_WRAM: begin
               r.mem_address = 19'(a & 32'h1fff);
               r.mem_select = SEL_WRAM;
               r.access_allowed = wram_en;
            end
            default: ;
         endcase
         r.irq_line = irq_pending;
         expected_rsp.push_back(r);
      endfunction

      // Compare one response beat with the oldest outstanding expectation
      function void check_rsp(logic [23:0] tdata, logic [2:0] tuser);
         mapper_rsp_type got, want;
         got.mem_address = tdata[18:0];
         got.access_allowed = tdata[19];
         got.irq_line = tdata[20];
         got.mem_select = tuser;
         checked++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d: response with nothing outstanding, tdata %h tuser %h",
                        checked, tdata, tuser);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.mem_address !== want.mem_address || got.mem_select !== want.mem_select ||
             got.access_allowed !== want.access_allowed || got.irq_line !== want.irq_line ||
             tdata[23:21] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d exp/act: addr %h/%h sel %0d/%0d allow %b/%b irq %b/%b pad %b",
                        checked, want.mem_address, got.mem_address,
                        want.mem_select, got.mem_select, want.access_allowed,
                        got.access_allowed, want.irq_line, got.irq_line, tdata[23:21]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] bus_address, [23:16] write_data
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // [18:0] mem_address, [19] access_allowed, [20] irq_line
   logic [2:0]  rsp_tuser;       // [2:0] mem_select
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_wdata = '0;

   bank_irq_tracker_type tracker;
   logic cur_swap = 1'b0;
   int   items_sent = 0;
   int   send_burst = 0;
   int   rsp_count = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   ready_burst = 0;

   cartridge_mapper_bank_irq dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Address that hits the given register under the current line-swap setting
   function automatic logic [15:0] reg_addr(logic [15:0] code);
      logic [15:0] rnd;
      rnd = 16'($urandom);
      if (cur_swap) return (code & 16'hf000) | {11'b0, code[3], 4'b0} | (rnd & 16'h0fef);
      return (code & 16'hf008) | (rnd & 16'h0ff7);
   endfunction

   function automatic logic [15:0] rand_reg(int top_nibble);
      return reg_addr({4'($urandom_range(8, top_nibble)), 8'h00, 1'($urandom_range(0, 1)),
                       3'b000});
   endfunction

   // Half fully random, half inside the window the kind normally uses
   function automatic logic [15:0] rand_addr(logic [2:0] kind);
      logic [15:0] rnd;
      rnd = 16'($urandom);
      if ($urandom_range(0, 1)) return rnd;
      case (kind)
         REQ_PRG:             return rnd | 16'h8000;
         REQ_CHR_RD, REQ_CHR_WR: return rnd & 16'h1fff;
         REQ_NT:              return 16'h2000 | (rnd & 16'h0fff);
         REQ_WRAM:            return 16'h6000 | (rnd & 16'h1fff);
         default:             return rnd;
      endcase
   endfunction

   // Data biased toward the top so the IRQ latch sits near wrap
   function automatic logic [7:0] rand_data();
      if ($urandom_range(0, 1)) return 8'($urandom);
      return 8'($urandom_range(8'hf8, 8'hff));
   endfunction

   // Offer one event beat after a random gap and record it once accepted
   task automatic send_event(logic [2:0] kind, logic [15:0] addr, logic [7:0] data);
      int gap, r;
      if (send_burst > 0) begin
         send_burst--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_burst = $urandom_range(5, 40);
            gap = 0;
         end else if (r < 85) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(8, 40);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {data, addr};
      do @(posedge clock); while (!req_tready);
      tracker.note_event(kind, addr, data);
      items_sent++;
   endtask

   // Stop offering and wait for every owed response, then let the pipe settle
   task automatic drain_events();
      req_tvalid <= 1'b0;
      while (tracker.expected_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(logic [4:0] prg_log2, logic [4:0] chr_log2, logic swap);
      csr_we <= 1'b1;
      csr_index <= CFG_PRG_LOG2;
      csr_wdata <= prg_log2;
      @(posedge clock);
      csr_index <= CFG_CHR_LOG2;
      csr_wdata <= chr_log2;
      @(posedge clock);
      csr_index <= CFG_SWAP;
      csr_wdata <= {4'b0, swap};
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(CFG_PRG_LOG2, prg_log2);
      tracker.set_reg(CFG_CHR_LOG2, chr_log2);
      tracker.set_reg(CFG_SWAP, {4'b0, swap});
      cur_swap = swap;
      @(posedge clock);
   endtask

   // Random traffic built from IRQ runs, bank reprogramming and plain noise
   task automatic run_random(int goal);
      int          stop_at, r;
      logic [2:0]  kind;
      logic [7:0]  ctrl;
      stop_at = items_sent + goal;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            // latch near wrap, enable, then mostly ticks
            send_event(REQ_WRITE, reg_addr(REG_LATCH),
                       $urandom_range(0, 1) ? 8'hff : rand_data());
            ctrl = 8'($urandom);
            ctrl[1] = 1'b1;
            send_event(REQ_WRITE, reg_addr(REG_IRQ_CTRL), ctrl);
            repeat ($urandom_range(10, 160)) begin
               kind = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(REQ_PRG, REQ_WRAM))
                                                   : REQ_TICK;
               send_event(kind, rand_addr(kind), rand_data());
            end
            if ($urandom_range(0, 3) != 0)
               send_event(REQ_WRITE, reg_addr(REG_IRQ_ACK), rand_data());
         end else if (r < 55) begin
            // bank, mirroring and IRQ latch writes followed by lookups
            repeat ($urandom_range(1, 6)) send_event(REQ_WRITE, rand_reg(14), rand_data());
            repeat ($urandom_range(4, 20)) begin
               kind = 3'($urandom_range(REQ_PRG, REQ_WRAM));
               send_event(kind, rand_addr(kind), rand_data());
            end
         end else begin
            // any kind, with writes mostly aimed at mapper registers
            repeat ($urandom_range(5, 30)) begin
               kind = 3'($urandom_range(0, 7));
               send_event(kind, (kind == REQ_WRITE && $urandom_range(0, 3) != 0) ?
                          rand_reg(15) : rand_addr(kind), rand_data());
            end
         end
      end
   endtask

   // Response side: check each beat, stall at random, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_rsp(rsp_tdata, rsp_tuser);
         rsp_count++;
         if (rsp_count == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_burst > 0) begin
         ready_burst--;
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               ready_burst = $urandom_range(1, 30);
               rsp_tready <= 1'b1;
            end
            9: begin
               stall_left = $urandom_range(10, 40);
               rsp_tready <= 1'b0;
            end
            default: begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end
         endcase
      end
   end

   // Watchdog: too long without any beat on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: window edges, banking, mirroring, ignored writes, one IRQ fire and ack
      send_event(REQ_TICK, 16'h0000, 8'h00);
      send_event(REQ_PRG, 16'h0000, 8'h00);
      send_event(REQ_PRG, 16'hffff, 8'h00);
      send_event(REQ_WRITE, REG_PRG0, 8'hff);
      send_event(REQ_WRITE, REG_PRG2, 8'h2a);
      send_event(REQ_PRG, 16'h8abc, 8'h00);
      send_event(REQ_PRG, 16'hdfff, 8'h00);
      send_event(REQ_WRITE, REG_CHR0, 8'hff);
      send_event(REQ_WRITE, REG_CHR7, 8'h81);
      send_event(REQ_CHR_RD, 16'hffff, 8'h00);
      send_event(REQ_CHR_WR, 16'h03ff, 8'h00);
      send_event(REQ_NT, 16'h2fff, 8'h00);
      send_event(REQ_WRITE, REG_MIRROR, 8'h81);
      send_event(REQ_NT, 16'h2c05, 8'h00);
      send_event(REQ_WRAM, 16'h7fff, 8'h00);
      send_event(REQ_WRITE, REG_MIRROR, 8'h02);
      send_event(REQ_NT, 16'h27ff, 8'h00);
      send_event(REQ_WRITE, REG_MIRROR, 8'h03);
      send_event(REQ_NT, 16'h2000, 8'h00);
      send_event(REQ_WRAM, 16'h6000, 8'h00);
      send_event(REQ_WRITE, REG_SOUND, 8'hff);
      send_event(REQ_WRITE, 16'h7fff, 8'hff);
      send_event(REQ_UNUSED, 16'hffff, 8'hff);
      send_event(REQ_WRITE, REG_LATCH, 8'hff);
      send_event(REQ_WRITE, REG_IRQ_CTRL, 8'h07);
      send_event(REQ_TICK, 16'h0000, 8'h00);
      send_event(REQ_WRITE, REG_IRQ_ACK, 8'h00);

      run_random(ITEMS_PER_PHASE);
      drain_events();
      apply_config(PRG_LOG2_MIN, 5'd18, 1'b1);
      run_random(ITEMS_PER_PHASE);
      drain_events();
      // out-of-range sizes saturate
      apply_config(5'd0, 5'd31, 1'b0);
      run_random(ITEMS_PER_PHASE);
      drain_events();
      apply_config(5'd31, 5'd1, 1'b1);
      run_random(ITEMS_PER_PHASE);
      drain_events();
      apply_config(5'($urandom), 5'($urandom), 1'($urandom));
      run_random(ITEMS_PER_PHASE);
      drain_events();

      if (tracker.mismatches == 0 && tracker.expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
